@@ rtl/core/wmm_pkg.sv @@
// wmm_pkg: shared constants, register codes and payload types of the
// windowed max / min / median filter. No dependencies.
`default_nettype none

package wmm_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_WINDOW   = 7;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int LINES        = MAX_WINDOW - 1;
  localparam int AREA         = MAX_WINDOW * MAX_WINDOW;
  localparam int HALF_MAX     = MAX_WINDOW / 2;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int CFG_W  = 11;
  localparam int SIZE_W = 3;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LINE_W = $clog2(LINES);
  localparam int RSAT_W = $clog2(LINES + 1);
  localparam int HALF_W = $clog2(HALF_MAX + 1);
  localparam int POS_W  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + HALF_MAX * (MAX_WIDTH + 1)) + 1;
  localparam int DIST_W = $clog2(HALF_MAX * (MAX_WIDTH + 1) + 1);
  localparam int RANK_W = $clog2(AREA);
  localparam int CNT_W  = $clog2(AREA + 1);
  localparam int NSEL   = 3;

  // order of the three rank searches
  localparam int SEL_MAX = 0;
  localparam int SEL_MIN = 1;
  localparam int SEL_MED = 2;

  localparam int WIDTH_RST = 512;
  localparam int HEIGHT_RST = 512;
  localparam int HALF_RST  = 1;

  typedef enum logic [1:0] {
    REG_WINDOW_SIZE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_flush;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] max_value;
    logic [PIX_W-1:0] min_value;
    logic [PIX_W-1:0] median_value;
    logic             end_of_frame;
  } res_t;

  // one masked window on its way into the rank search
  typedef struct packed {
    logic [AREA-1:0][PIX_W-1:0] vals;
    logic [AREA-1:0]            act;
    logic [RANK_W-1:0]          rank_max;
    logic [RANK_W-1:0]          rank_med;
    logic                       eof;
  } win_t;

endpackage

`default_nettype wire

@@ rtl/core/window_min_max_median_filter_top.sv @@
// window_min_max_median_filter_top: raster-stream k x k max / min / median
// filter. Depends on wmm_pkg, wmm_ram and wmm_rank_sel.
//
// Usage:
//   pixels enter on pix_valid / pix_stall / pix in raster order, one per
//   transfer; is_flush items stand for the zero padding after the frame.
//   results leave on res_valid / res_stall / res, at most one per item.
//   the result of a pixel follows the item that arrives (k/2) rows plus
//   (k/2) pixels after it and leaves through the read-data stage and the
//   rank search. throughput is one item per cycle while res_stall holds no
//   result: six line RAMs are read at one column and one is written in
//   the same cycle; the rank search has eight stages, one pixel bit each.
//   cfg_write / cfg_index / cfg_data write window_size, image_width and
//   image_height; a write to one of these restarts the frame. write only while idle.
//   reset sets 3 / 512 / 512, clears the counters and the window; the line
//   RAMs need no clearing pass since rows above the frame are masked.
//   when res_stall holds a result, the whole pipe holds and pix_stall rises.
//   end_of_frame marks the last pixel; the next item starts a new frame.
`default_nettype none

module window_min_max_median_filter_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [wmm_pkg::CFG_W-1:0] cfg_data,
  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  wmm_pkg::pix_t             pix,
  output logic                      res_valid,
  input  logic                      res_stall,
  output wmm_pkg::res_t             res
);

  localparam int DIM_W  = wmm_pkg::DIM_W;
  localparam int POS_W  = wmm_pkg::POS_W;
  localparam int DIST_W = wmm_pkg::DIST_W;
  localparam int HALF_W = wmm_pkg::HALF_W;
  localparam int COL_W  = wmm_pkg::COL_W;
  localparam int LINE_W = wmm_pkg::LINE_W;
  localparam int RSAT_W = wmm_pkg::RSAT_W;
  localparam int PIX_W  = wmm_pkg::PIX_W;
  localparam int MW     = wmm_pkg::MAX_WINDOW;
  localparam int LINES  = wmm_pkg::LINES;

  // effective configuration
  logic [DIM_W-1:0]  width_eff, width_next;
  logic [DIM_W-1:0]  height_eff, height_next;
  logic [HALF_W-1:0] half, half_next;
  logic [POS_W-1:0]  total, total_next;
  logic [DIST_W-1:0] offset, offset_next;
  logic              cfg_hit;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [wmm_pkg::CFG_W-1:0] d,
                                               input int limit);
    logic [DIM_W-1:0] r;
    r = DIM_W'(d);
    if (r == '0) begin
      r = DIM_W'(1);
    end else if (r > DIM_W'(limit)) begin
      r = DIM_W'(limit);
    end
    return r;
  endfunction

  always_comb begin
    logic [wmm_pkg::SIZE_W-1:0] k;
    logic [2*DIM_W-1:0]         prod;
    logic [DIST_W+HALF_W:0]     dsum;
    width_next  = width_eff;
    height_next = height_eff;
    half_next   = half;
    cfg_hit     = 1'b1;
    k = cfg_data[wmm_pkg::SIZE_W-1:0];
    if (k > wmm_pkg::SIZE_W'(MW)) begin
      k = wmm_pkg::SIZE_W'(MW);
    end
    case (cfg_index)
      wmm_pkg::REG_WINDOW_SIZE: begin
        // even sides drop to the next smaller odd side, zero acts as one
        half_next = (k == '0) ? '0 : HALF_W'((k - 1'b1) >> 1);
      end
      wmm_pkg::REG_IMAGE_WIDTH: begin
        width_next = sat_dim(cfg_data, wmm_pkg::MAX_WIDTH);
      end
      wmm_pkg::REG_IMAGE_HEIGHT: begin
        height_next = sat_dim(cfg_data, wmm_pkg::HEIGHT_LIMIT);
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
    prod        = (2*DIM_W)'(width_next) * (2*DIM_W)'(height_next);
    total_next  = POS_W'(prod);
    dsum        = (DIST_W+HALF_W+1)'(half_next) * (DIST_W+HALF_W+1)'(width_next)
                + (DIST_W+HALF_W+1)'(half_next);
    offset_next = DIST_W'(dsum);
  end

  // stream counters
  logic [COL_W-1:0]  col, col_next;
  logic [LINE_W-1:0] line, line_next;
  logic [RSAT_W-1:0] rsat, rsat_next;
  logic [POS_W-1:0]  pos;
  logic [COL_W-1:0]  ocol, ocol_next;

  logic             en, acc;
  logic [PIX_W-1:0] val;
  logic             emit, eof, restart;
  logic [MW-1:0]    cmask;

  assign en        = !(res_valid && res_stall);
  assign pix_stall = !en;
  assign acc       = pix_valid && en;

  always_comb begin
    logic [POS_W-1:0] q;
    logic             zone;
    logic [DIM_W-1:0] x;
    val  = (pos < total && !pix.is_flush) ? pix.pixel : '0;
    zone = pos >= POS_W'(offset);
    q    = pos - POS_W'(offset);
    emit    = zone && (q < total);
    eof     = emit && (q == total - 1'b1);
    restart = zone && (!(q < total) || eof);

    if (DIM_W'(col) + 1'b1 >= width_eff) begin
      col_next  = '0;
      line_next = (line == LINE_W'(LINES - 1)) ? '0 : line + 1'b1;
      rsat_next = (rsat == RSAT_W'(LINES)) ? rsat : rsat + 1'b1;
    end else begin
      col_next  = col + 1'b1;
      line_next = line;
      rsat_next = rsat;
    end
    ocol_next = (DIM_W'(ocol) + 1'b1 >= width_eff) ? '0 : ocol + 1'b1;

    // window column j covers image column ocol + half - j
    x = DIM_W'(ocol) + DIM_W'(half);
    for (int j = 0; j < MW; j++) begin
      cmask[j] = (x >= DIM_W'(j)) && ((x - DIM_W'(j)) < width_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= DIM_W'(wmm_pkg::WIDTH_RST);
      height_eff <= DIM_W'(wmm_pkg::HEIGHT_RST);
      half       <= HALF_W'(wmm_pkg::HALF_RST);
      total      <= POS_W'(wmm_pkg::WIDTH_RST * wmm_pkg::HEIGHT_RST);
      offset     <= DIST_W'(wmm_pkg::HALF_RST * (wmm_pkg::WIDTH_RST + 1));
      col  <= '0;
      line <= '0;
      rsat <= '0;
      pos  <= '0;
      ocol <= '0;
    end else if (cfg_write && cfg_hit) begin
      width_eff  <= width_next;
      height_eff <= height_next;
      half       <= half_next;
      total      <= total_next;
      offset     <= offset_next;
      col  <= '0;
      line <= '0;
      rsat <= '0;
      pos  <= '0;
      ocol <= '0;
    end else if (acc) begin
      if (restart) begin
        col  <= '0;
        line <= '0;
        rsat <= '0;
        pos  <= '0;
        ocol <= '0;
      end else begin
        col  <= col_next;
        line <= line_next;
        rsat <= rsat_next;
        pos  <= pos + 1'b1;
        if (emit) begin
          ocol <= ocol_next;
        end
      end
    end
  end

  // line RAMs, one per stored row
  logic [PIX_W-1:0] rd [LINES];

  for (genvar l = 0; l < LINES; l++) begin : g_line
    wmm_ram #(
      .WIDTH(PIX_W),
      .DEPTH(wmm_pkg::MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   (acc && (line == LINE_W'(l))),
      .waddr(col),
      .wdata(val),
      .re   (acc),
      .raddr(col),
      .rdata(rd[l])
    );
  end

  // read-data stage
  logic              s1_v, s1_emit, s1_eof;
  logic [PIX_W-1:0]  s1_val;
  logic [LINE_W-1:0] s1_line;
  logic [RSAT_W-1:0] s1_rsat;
  logic [MW-1:0]     s1_cmask;
  logic [HALF_W-1:0] s1_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_emit  <= emit;
      s1_eof   <= eof;
      s1_val   <= val;
      s1_line  <= line;
      s1_rsat  <= rsat;
      s1_cmask <= cmask;
      s1_half  <= half;
    end
  end

  logic [PIX_W-1:0] column [MW];
  logic [PIX_W-1:0] win [MW][MW];
  logic [PIX_W-1:0] win_next [MW][MW];
  wmm_pkg::win_t    sel_in;

  always_comb begin
    logic [LINE_W:0] idx;
    column[0] = s1_val;
    for (int i = 1; i < MW; i++) begin
      // row r-i sits in line (r - i) mod LINES
      idx = (LINE_W+1)'(s1_line) + (LINE_W+1)'(LINES - i);
      if (idx >= (LINE_W+1)'(LINES)) begin
        idx = idx - (LINE_W+1)'(LINES);
      end
      column[i] = (s1_rsat >= RSAT_W'(i)) ? rd[idx[LINE_W-1:0]] : '0;
    end
    for (int i = 0; i < MW; i++) begin
      win_next[i][0] = column[i];
      for (int j = 1; j < MW; j++) begin
        win_next[i][j] = win[i][j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MW; i++) begin
        for (int j = 0; j < MW; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (en && s1_v) begin
      win <= win_next;
    end
  end

  always_comb begin
    logic [HALF_W:0]          span;
    logic [2*(HALF_W+1)-1:0] n_sq;
    span = (HALF_W+1)'(s1_half) << 1;
    n_sq = (2*(HALF_W+1))'(span + 1'b1) * (2*(HALF_W+1))'(span + 1'b1);
    for (int i = 0; i < MW; i++) begin
      for (int j = 0; j < MW; j++) begin
        sel_in.vals[i*MW+j] = s1_cmask[j] ? win_next[i][j] : '0;
        sel_in.act[i*MW+j]  = ((HALF_W+1)'(i) <= span) && ((HALF_W+1)'(j) <= span);
      end
    end
    sel_in.rank_max = wmm_pkg::RANK_W'(n_sq - 1'b1);
    sel_in.rank_med = wmm_pkg::RANK_W'((n_sq - 1'b1) >> 1);
    sel_in.eof      = s1_eof;
  end

  wmm_rank_sel u_rank (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s1_v && s1_emit),
    .win      (sel_in),
    .out_valid(res_valid),
    .out_res  (res)
  );

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line <= LINE_W'(LINES - 1))
    else $error("line index out of range");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    DIM_W'(col) < width_eff)
    else $error("column counter beyond image width");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (POS_W+1)'(pos) < (POS_W+1)'(total) + (POS_W+1)'(offset))
    else $error("position counter past frame end");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    acc && eof && !cfg_write |=> pos == '0 && col == '0 && ocol == '0)
    else $error("counters not cleared after frame end");

endmodule

`default_nettype wire

@@ rtl/core/wmm_ram.sv @@
// wmm_ram: generic single-clock RAM, one write port and one registered
// read port, read-before-write on the same address. No dependencies.
`default_nettype none

module wmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wmm_rank_sel.sv @@
// wmm_rank_sel: bit-serial rank search over one window, one bit per stage,
// giving max, min and median in parallel. Depends on wmm_pkg.
`default_nettype none

module wmm_rank_sel (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  wmm_pkg::win_t win,
  output logic          out_valid,
  output wmm_pkg::res_t out_res
);

  localparam int STAGES = wmm_pkg::PIX_W;

  logic                                         v    [STAGES+1];
  logic                                         eof  [STAGES+1];
  logic [wmm_pkg::AREA-1:0][wmm_pkg::PIX_W-1:0] vals [STAGES+1];
  logic [wmm_pkg::AREA-1:0]   cand [STAGES+1][wmm_pkg::NSEL];
  logic [wmm_pkg::RANK_W-1:0] rk   [STAGES+1][wmm_pkg::NSEL];
  logic [wmm_pkg::PIX_W-1:0]  rv   [STAGES+1][wmm_pkg::NSEL];

  function automatic logic [wmm_pkg::CNT_W-1:0] count_ones(input logic [wmm_pkg::AREA-1:0] x);
    logic [wmm_pkg::CNT_W-1:0] n;
    n = '0;
    for (int e = 0; e < wmm_pkg::AREA; e++) begin
      n = n + wmm_pkg::CNT_W'(x[e]);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eof[0]  <= win.eof;
      vals[0] <= win.vals;
      for (int s = 0; s < wmm_pkg::NSEL; s++) begin
        cand[0][s] <= win.act;
        rv[0][s]   <= '0;
      end
      rk[0][wmm_pkg::SEL_MAX] <= win.rank_max;
      rk[0][wmm_pkg::SEL_MIN] <= '0;
      rk[0][wmm_pkg::SEL_MED] <= win.rank_med;
    end
  end

  for (genvar t = 0; t < STAGES; t++) begin : g_stage
    localparam int B = wmm_pkg::PIX_W - 1 - t;

    logic [wmm_pkg::AREA-1:0]   ones;
    logic [wmm_pkg::AREA-1:0]   cand_next [wmm_pkg::NSEL];
    logic [wmm_pkg::RANK_W-1:0] rk_next   [wmm_pkg::NSEL];
    logic [wmm_pkg::PIX_W-1:0]  rv_next   [wmm_pkg::NSEL];

    always_comb begin
      logic [wmm_pkg::AREA-1:0]  zeros;
      logic [wmm_pkg::CNT_W-1:0] cnt;
      for (int e = 0; e < wmm_pkg::AREA; e++) begin
        ones[e] = vals[t][e][B];
      end
      for (int s = 0; s < wmm_pkg::NSEL; s++) begin
        zeros = cand[t][s] & ~ones;
        cnt   = count_ones(zeros);
        rv_next[s] = rv[t][s];
        // rank falls among the candidates with a zero here
        if (rk[t][s] < cnt) begin
          cand_next[s]  = zeros;
          rk_next[s]    = rk[t][s];
          rv_next[s][B] = 1'b0;
        end else begin
          cand_next[s]  = cand[t][s] & ones;
          rk_next[s]    = rk[t][s] - cnt;
          rv_next[s][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[t+1] <= 1'b0;
      end else if (en) begin
        v[t+1] <= v[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        eof[t+1]  <= eof[t];
        vals[t+1] <= vals[t];
        for (int s = 0; s < wmm_pkg::NSEL; s++) begin
          cand[t+1][s] <= cand_next[s];
          rk[t+1][s]   <= rk_next[s];
          rv[t+1][s]   <= rv_next[s];
        end
      end
    end
  end

  assign out_valid            = v[STAGES];
  assign out_res.max_value    = rv[STAGES][wmm_pkg::SEL_MAX];
  assign out_res.min_value    = rv[STAGES][wmm_pkg::SEL_MIN];
  assign out_res.median_value = rv[STAGES][wmm_pkg::SEL_MED];
  assign out_res.end_of_frame = eof[STAGES];

endmodule

`default_nettype wire
